FILE: design/c2br_pkg.sv
package c2br_pkg;

  localparam int KERNEL_DEF    = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int DATA_W     = 16;
  localparam int WIDX_W     = 4;
  localparam int ACT_W      = 26;
  localparam int DIM_CFG_W  = 11;
  localparam int ROW_W      = 10;
  localparam int HEIGHT_CAP = 1024;
  localparam int FRAC_W     = 8;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACT_MAX    = (2 ** ACT_W) - 1;

  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = DIM_CFG_W'(28);
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = DIM_CFG_W'(28);
  localparam logic [DATA_W-1:0]    BIAS_RST   = '0;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BIAS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] width;
    logic [DIM_CFG_W-1:0] height;
    logic [DATA_W-1:0]    bias;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic frame_end;
  } tag_t;

endpackage

FILE: design/c2br_if.sv
interface c2br_in_if import c2br_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [DATA_W-1:0] pixel;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [DATA_W-1:0] weight;

  modport source (output valid, func, pixel, weight_index, weight, input ready);
  modport sink (input valid, func, pixel, weight_index, weight, output ready);
endinterface

interface c2br_out_if import c2br_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] activation;
  logic             positive;
  logic             frame_end;

  modport source (output valid, activation, positive, frame_end, input ready);
  modport sink (input valid, activation, positive, frame_end, output ready);
endinterface

FILE: design/conv2d_bias_relu_stream.sv
// Stages from input transfer to result: stage A, tap products, adder-tree levels, output.
// Throughput: one item per cycle while the output is not stalled; the line store takes
// one read and one write each cycle and the tap cells and adder tree are fully pipelined.
// Reset (rst_n low, synchronous): counters, kernel and window cleared, registers to defaults.
// The line store is not cleared; every column a result uses is written earlier in the frame.
module conv2d_bias_relu_stream import c2br_pkg::*; #(
  parameter int KERNEL    = KERNEL_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  c2br_in_if.sink           in_chan,
  c2br_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int TAPS   = KERNEL * KERNEL;
  localparam int SLOTS  = KERNEL - 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CLW    = $clog2(MAX_WIDTH + 1);
  localparam int DIM_W  = ((CLW > DIM_CFG_W) ? CLW : DIM_CFG_W) + 1;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int SHR_W  = ACC_W - FRAC_W;
  localparam int SUM_W  = SHR_W + 1;
  localparam logic signed [SUM_W-1:0] ACT_MAX_S = SUM_W'(ACT_MAX);

  cfg_t cfg;

  c2br_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame geometry
  logic [DIM_W-1:0] width_x, height_x, w_eff, h_eff;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_col, last_row, emit;

  assign width_x  = DIM_W'(cfg.width);
  assign height_x = DIM_W'(cfg.height);

  always_comb begin
    if (width_x < DIM_W'(KERNEL)) begin
      w_eff = DIM_W'(KERNEL);
    end else if (width_x > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end
    if (height_x < DIM_W'(KERNEL)) begin
      h_eff = DIM_W'(KERNEL);
    end else if (height_x > DIM_W'(HEIGHT_CAP)) begin
      h_eff = DIM_W'(HEIGHT_CAP);
    end else begin
      h_eff = height_x;
    end
  end

  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= w_eff;
  assign last_row = (DIM_W'(row_r) + DIM_W'(1)) >= h_eff;
  assign emit     = (row_r >= ROW_W'(KERNEL - 1)) && (col_r >= COL_W'(KERNEL - 1));

  // handshake and stage A
  logic adv, in_go, b_go, b_px;
  logic out_valid_r;

  logic                     a_valid_r;
  logic                     a_func_r;
  logic signed [DATA_W-1:0] a_px_r;
  logic [WIDX_W-1:0]        a_widx_r;
  logic signed [DATA_W-1:0] a_wt_r;
  logic [COL_W-1:0]         a_col_r;
  logic                     a_emit_r;
  logic                     a_fend_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !a_valid_r || adv;
  assign in_go         = in_chan.valid && in_chan.ready;
  assign b_go          = a_valid_r && adv;
  assign b_px          = b_go && !a_func_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_go && !in_chan.func) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_go) begin
        a_valid_r <= 1'b1;
      end else if (adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      a_func_r <= in_chan.func;
      a_px_r   <= in_chan.pixel;
      a_widx_r <= in_chan.weight_index;
      a_wt_r   <= in_chan.weight;
      a_col_r  <= col_r;
      a_emit_r <= emit;
      a_fend_r <= last_col && last_row;
    end
  end

  // line store
  logic [DATA_W*SLOTS-1:0] mem_q;

  c2br_line_buf #(
    .DEPTH (MAX_WIDTH),
    .SLOTS (SLOTS)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_go),
    .rd_addr (col_r),
    .rd_data (mem_q),
    .wr_en   (b_px),
    .wr_addr (a_col_r),
    .px      (a_px_r)
  );

  // tap cells, row-major; each shifts left into its neighbour
  logic signed [DATA_W-1:0] win  [TAPS];
  logic signed [DATA_W-1:0] sin  [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic [TAPS-1:0]          load;

  genvar r, c;
  generate
    for (r = 0; r < KERNEL; r++) begin : g_row
      for (c = 0; c < KERNEL; c++) begin : g_col
        if (c < KERNEL - 1) begin : g_inner
          assign sin[r*KERNEL+c] = win[r*KERNEL+c+1];
        end else if (r < KERNEL - 1) begin : g_edge
          assign sin[r*KERNEL+c] = mem_q[DATA_W*r +: DATA_W];
        end else begin : g_new
          assign sin[r*KERNEL+c] = a_px_r;
        end

        assign load[r*KERNEL+c] = b_go && a_func_r && (int'(a_widx_r) == r*KERNEL+c);

        c2br_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (b_px),
          .load_en  (load[r*KERNEL+c]),
          .load_val (a_wt_r),
          .shift_in (sin[r*KERNEL+c]),
          .win_out  (win[r*KERNEL+c]),
          .prod_out (prod[r*KERNEL+c])
        );
      end
    end
  endgenerate

  tag_t b_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r <= '0;
    end else if (adv) begin
      b_tag_r.valid     <= b_px && a_emit_r;
      b_tag_r.frame_end <= a_fend_r;
    end
  end

  // adder tree
  logic signed [ACC_W-1:0] acc;
  tag_t                    t_tag;

  c2br_sum_tree #(
    .N     (TAPS),
    .OUT_W (ACC_W)
  ) u_sum_tree (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .prod_in (prod),
    .in_tag  (b_tag_r),
    .sum     (acc),
    .out_tag (t_tag)
  );

  // shift, bias, rectify, saturate
  logic signed [SHR_W-1:0]  shr;
  logic signed [DATA_W-1:0] bias_s;
  logic signed [SUM_W-1:0]  s;
  logic [ACT_W-1:0]         act_nxt;
  logic                     pos_nxt;

  assign shr    = acc[ACC_W-1:FRAC_W];
  assign bias_s = signed'(cfg.bias);
  assign s      = SUM_W'(shr) + SUM_W'(bias_s);

  always_comb begin
    pos_nxt = !s[SUM_W-1] && (s != '0);
    if (s > ACT_MAX_S) begin
      act_nxt = ACT_W'(ACT_MAX);
    end else if (pos_nxt) begin
      act_nxt = s[ACT_W-1:0];
    end else begin
      act_nxt = '0;
    end
  end

  logic [ACT_W-1:0] act_r;
  logic             pos_r;
  logic             fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= t_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_r  <= act_nxt;
      pos_r  <= pos_nxt;
      fend_r <= t_tag.frame_end;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.activation = act_r;
  assign out_chan.positive   = pos_r;
  assign out_chan.frame_end  = fend_r;

endmodule

FILE: design/c2br_cfg.sv
module c2br_cfg import c2br_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_reg_t idx;
  logic     wr_go;

  assign idx    = cfg_reg_t'(paddr[3:2]);
  assign wr_go  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
      cfg_r.bias   <= BIAS_RST;
    end else if (wr_go) begin
      case (idx)
        REG_WIDTH:  cfg_r.width  <= pwdata[DIM_CFG_W-1:0];
        REG_HEIGHT: cfg_r.height <= pwdata[DIM_CFG_W-1:0];
        REG_BIAS:   cfg_r.bias   <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DW'(cfg_r.width);
      REG_HEIGHT: prdata = APB_DW'(cfg_r.height);
      REG_BIAS:   prdata = APB_DW'(cfg_r.bias);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/c2br_line_buf.sv
module c2br_line_buf import c2br_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int SLOTS = KERNEL_DEF - 1
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [DATA_W*SLOTS-1:0]   rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [DATA_W-1:0]         px
);

  localparam int LINE_W = DATA_W * SLOTS;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_q_r;
  logic [LINE_W-1:0] wr_row;

  // move each slot of the column up one row, newest pixel into the top slot
  generate
    if (SLOTS == 1) begin : g_one
      assign wr_row = px;
    end else begin : g_many
      assign wr_row = {px, rd_q_r[LINE_W-1:DATA_W]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

FILE: design/c2br_cell.sv
module c2br_cell import c2br_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic                     load_en,
  input  logic signed [DATA_W-1:0] load_val,
  input  logic signed [DATA_W-1:0] shift_in,
  output logic signed [DATA_W-1:0] win_out,
  output logic signed [PROD_W-1:0] prod_out
);

  logic signed [DATA_W-1:0] win_r;
  logic signed [DATA_W-1:0] ker_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      ker_r <= '0;
    end else begin
      if (shift_en) begin
        win_r <= shift_in;
      end
      if (load_en) begin
        ker_r <= load_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      prod_r <= PROD_W'(shift_in * ker_r);
    end
  end

  assign win_out  = win_r;
  assign prod_out = prod_r;

endmodule

FILE: design/c2br_sum_tree.sv
module c2br_sum_tree import c2br_pkg::*; #(
  parameter int N     = KERNEL_DEF * KERNEL_DEF,
  parameter int OUT_W = PROD_W + $clog2(KERNEL_DEF * KERNEL_DEF)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic signed [PROD_W-1:0] prod_in [N],
  input  tag_t                     in_tag,
  output logic signed [OUT_W-1:0]  sum,
  output tag_t                     out_tag
);

  localparam int LEVELS = $clog2(N);

  logic signed [OUT_W-1:0] lvl_r [LEVELS][N];
  logic signed [OUT_W-1:0] pad   [LEVELS][2*N];
  tag_t                    tag_r [LEVELS];

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < 2 * N; k++) begin
        pad[l][k] = '0;
      end
    end
    for (int k = 0; k < N; k++) begin
      pad[0][k] = OUT_W'(prod_in[k]);
    end
    for (int l = 1; l < LEVELS; l++) begin
      for (int k = 0; k < N; k++) begin
        pad[l][k] = lvl_r[l-1][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LEVELS; l++) begin
        for (int k = 0; k < N; k++) begin
          lvl_r[l][k] <= pad[l][2*k] + pad[l][2*k+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        tag_r[l] <= '0;
      end
    end else if (adv) begin
      tag_r[0] <= in_tag;
      for (int l = 1; l < LEVELS; l++) begin
        tag_r[l] <= tag_r[l-1];
      end
    end
  end

  assign sum     = lvl_r[LEVELS-1][0];
  assign out_tag = tag_r[LEVELS-1];

endmodule
